// ===== design/lmsd_pkg.sv =====
`default_nettype none
package lmsd_pkg;

   localparam int MaxNumbers = 1024;
   localparam int AddrWidth  = $clog2(MaxNumbers);
   localparam int CountWidth = $clog2(MaxNumbers + 1);
   localparam int ValueWidth = 24;
   localparam int PosWidth   = 16;
   localparam int SumWidth   = 34;
   localparam int DiffWidth  = 26;
   localparam int SqWidth    = 2 * DiffWidth;
   localparam int SumSqWidth = SqWidth + AddrWidth + 1;
   localparam int QueueDepth = 4;
   localparam int QueueAddrWidth = $clog2(QueueDepth);

   // one accepted item after classification
   typedef struct packed {
      logic                         store;
      logic                         last;
      logic signed [ValueWidth-1:0] value;
      logic [PosWidth-1:0]          position;
   } item_type;

   typedef struct packed {
      logic signed [ValueWidth-1:0] mean_value;
      logic [ValueWidth-1:0]        std_deviation;
      logic [CountWidth-1:0]        number_count;
      logic [PosWidth-1:0]          last_number_position;
      logic                         empty_list;
      logic                         overflowed;
   } result_type;

endpackage
`default_nettype wire

// ===== design/lmsd_front.sv =====
`default_nettype none
// Classify items: keep numbers, count them, track position and overflow.
module lmsd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic signed [23:0] req_sample_value,
   input  wire logic               req_is_number,
   input  wire logic [15:0]        req_position,
   input  wire logic               req_last_item,
   output lmsd_pkg::item_type      item_out,
   output logic                    item_valid,
   output logic                    list_overflow
);

   logic [lmsd_pkg::CountWidth-1:0] count_ff, count_in;
   logic                            ovf_ff, ovf_in;
   logic [15:0]                     pos_ff, pos_in;
   logic                            has_room;

   assign has_room = count_ff < lmsd_pkg::CountWidth'(lmsd_pkg::MaxNumbers);

   // decide what to do with this word
   always_comb begin
      item_out.store    = req_is_number && has_room;
      item_out.last     = req_last_item;
      item_out.value    = req_sample_value;
      item_out.position = req_is_number ? req_position : pos_ff;
      item_valid        = req_valid && (item_out.store || req_last_item);
      list_overflow     = ovf_ff || (req_is_number && !has_room);
      count_in = count_ff;
      ovf_in   = ovf_ff;
      pos_in   = pos_ff;
      if (req_valid) begin
         if (req_last_item) begin
            count_in = '0;
            ovf_in   = 1'b0;
            pos_in   = '0;
         end else begin
            if (item_out.store) count_in = count_ff + 1'b1;
            ovf_in = list_overflow;
            pos_in = item_out.position;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         pos_ff   <= '0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         pos_ff   <= pos_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/lmsd_queue.sv =====
`default_nettype none
// Short queue between front and back; the last word carries the list flags.
module lmsd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire lmsd_pkg::item_type push_item,
   input  wire logic               push_ovf,
   output logic                    full,
   input  wire logic               pop,
   output lmsd_pkg::item_type      pop_item,
   output logic                    pop_ovf,
   output logic                    empty
);

   lmsd_pkg::item_type mem_ff [lmsd_pkg::QueueDepth];
   logic               ovf_mem_ff [lmsd_pkg::QueueDepth];
   logic [lmsd_pkg::QueueAddrWidth:0] wr_ff, rd_ff;

   assign empty    = wr_ff == rd_ff;
   assign full     = (wr_ff[lmsd_pkg::QueueAddrWidth-1:0] == rd_ff[lmsd_pkg::QueueAddrWidth-1:0])
                     && (wr_ff[lmsd_pkg::QueueAddrWidth] != rd_ff[lmsd_pkg::QueueAddrWidth]);
   assign pop_item = mem_ff[rd_ff[lmsd_pkg::QueueAddrWidth-1:0]];
   assign pop_ovf  = ovf_mem_ff[rd_ff[lmsd_pkg::QueueAddrWidth-1:0]];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ff[lmsd_pkg::QueueAddrWidth-1:0]]     <= push_item;
         ovf_mem_ff[wr_ff[lmsd_pkg::QueueAddrWidth-1:0]] <= push_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         if (push && !full) wr_ff <= wr_ff + 1'b1;
         if (pop && !empty) rd_ff <= rd_ff + 1'b1;
      end
   end

   assert property (@(posedge clock) disable iff (reset) full |-> !empty)
      else $error("queue full and empty");
   assert property (@(posedge clock) disable iff (reset)
      (push && !full && !(pop && !empty)) |=> !empty)
      else $error("queue lost a word");
   assert property (@(posedge clock) disable iff (reset)
      (wr_ff - rd_ff) <= (lmsd_pkg::QueueAddrWidth+1)'(lmsd_pkg::QueueDepth))
      else $error("queue occupancy out of range");

endmodule
`default_nettype wire

// ===== design/lmsd_back.sv =====
`default_nettype none
// Store numbers, and at list end divide, sweep squares, root, and publish.
module lmsd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire lmsd_pkg::item_type in_item,
   input  wire logic               in_ovf,
   output logic                    in_pop,
   output lmsd_pkg::result_type    res,
   output logic                    res_valid,
   input  wire logic               res_pop
);

   localparam logic [2:0] StLoad = 3'd0, StDiv = 3'd1, StSweep = 3'd2, StDrain = 3'd3,
                          StSqDiv = 3'd4, StRoot = 3'd5, StDone = 3'd6;
   localparam int AW = lmsd_pkg::AddrWidth;
   localparam int CW = lmsd_pkg::CountWidth;
   localparam int SW = lmsd_pkg::SumWidth;
   localparam int QW = lmsd_pkg::SumSqWidth;
   localparam int DW = lmsd_pkg::DiffWidth;

   logic [2:0] state_ff;
   logic signed [lmsd_pkg::ValueWidth-1:0] store_mem [lmsd_pkg::MaxNumbers];
   logic signed [lmsd_pkg::ValueWidth-1:0] rd_data_ff;
   logic [CW-1:0] count_ff, idx_ff;
   logic signed [SW-1:0] sum_ff;
   logic [15:0] pos_ff;
   logic        ovf_ff;
   logic        neg_ff;
   logic [SW-1:0] quo_ff, rem_ff;
   logic [6:0]    step_ff;
   logic signed [SW-1:0] mean_ff;
   logic          rd_v_ff, sq_v_ff;
   logic [lmsd_pkg::SqWidth-1:0] sq_ff;
   logic [QW-1:0] acc_ff, vq_ff, vr_ff;
   logic [QW-1:0] root_ff, bit_ff;
   lmsd_pkg::result_type res_ff;
   logic          res_v_ff;

   logic [SW-1:0]   abs_sum, rem_sh;
   logic [QW-1:0]   vr_sh, rb;
   logic signed [DW-1:0] diff, adiff;
   logic [CW-1:0]   cnt_nx;

   assign in_pop    = (state_ff == StLoad) && in_valid;
   assign res       = res_ff;
   assign res_valid = res_v_ff;
   assign abs_sum   = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
   assign rem_sh    = {rem_ff[SW-2:0], quo_ff[SW-1]};
   assign vr_sh     = {vr_ff[QW-2:0], vq_ff[QW-1]};
   assign diff      = DW'(mean_ff) - DW'(rd_data_ff);
   assign adiff     = diff[DW-1] ? -diff : diff;
   assign rb        = root_ff + bit_ff;
   assign cnt_nx    = count_ff + CW'(in_item.store);

   // keep the number store; one write port, one registered read port
   always_ff @(posedge clock) begin
      if (in_pop && in_item.store)
         store_mem[count_ff[AW-1:0]] <= in_item.value;
      rd_data_ff <= store_mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StLoad;
         count_ff <= '0;
         sum_ff   <= '0;
         res_v_ff <= 1'b0;
         rd_v_ff  <= 1'b0;
         sq_v_ff  <= 1'b0;
      end else begin
         if (res_pop && res_v_ff && state_ff != StDone) res_v_ff <= 1'b0;
         case (state_ff)
            StLoad: begin
               if (in_pop) begin
                  count_ff <= cnt_nx;
                  if (in_item.store) sum_ff <= sum_ff + SW'(in_item.value);
                  pos_ff <= in_item.position;
                  ovf_ff <= in_ovf;
                  if (in_item.last) state_ff <= StDiv;
                  // prepare magnitude division of sum by count
                  quo_ff  <= in_item.store ?
                             ((sum_ff + SW'(in_item.value)) < 0 ?
                              SW'(-(sum_ff + SW'(in_item.value))) : SW'(sum_ff + SW'(in_item.value)))
                             : abs_sum;
                  neg_ff  <= in_item.store ? (sum_ff + SW'(in_item.value)) < 0 : sum_ff[SW-1];
                  rem_ff  <= '0;
                  step_ff <= '0;
               end
            end
            StDiv: begin
               // restoring divide, one quotient bit a cycle
               if (count_ff == '0) begin
                  state_ff <= StDone;
               end else begin
                  if (rem_sh >= SW'(count_ff)) begin
                     rem_ff <= rem_sh - SW'(count_ff);
                     quo_ff <= {quo_ff[SW-2:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh;
                     quo_ff <= {quo_ff[SW-2:0], 1'b0};
                  end
                  step_ff <= step_ff + 1'b1;
                  if (step_ff == 7'(SW - 1)) begin
                     state_ff <= StSweep;
                     idx_ff   <= '0;
                     acc_ff   <= '0;
                  end
               end
            end
            StSweep: begin
               // read, square, accumulate; one entry a cycle
               if (step_ff == 7'(SW)) begin
                  mean_ff <= neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
                  step_ff <= '0;
               end
               rd_v_ff <= (idx_ff < count_ff) && (step_ff == '0);
               if (idx_ff < count_ff && step_ff == '0) idx_ff <= idx_ff + 1'b1;
               sq_v_ff <= rd_v_ff;
               sq_ff   <= lmsd_pkg::SqWidth'($unsigned(adiff)) *
                          lmsd_pkg::SqWidth'($unsigned(adiff));
               if (sq_v_ff) acc_ff <= acc_ff + QW'(sq_ff);
               if (step_ff == '0 && idx_ff == count_ff && !rd_v_ff && !sq_v_ff)
                  state_ff <= StDrain;
            end
            StDrain: begin
               vq_ff    <= acc_ff;
               vr_ff    <= '0;
               step_ff  <= '0;
               state_ff <= StSqDiv;
            end
            StSqDiv: begin
               if (vr_sh >= QW'(count_ff)) begin
                  vr_ff <= vr_sh - QW'(count_ff);
                  vq_ff <= {vq_ff[QW-2:0], 1'b1};
               end else begin
                  vr_ff <= vr_sh;
                  vq_ff <= {vq_ff[QW-2:0], 1'b0};
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == 7'(QW - 1)) begin
                  state_ff <= StRoot;
                  root_ff  <= '0;
                  bit_ff   <= QW'(1) << (2 * ((QW - 1) / 2));
               end
            end
            StRoot: begin
               // digit-by-digit square root, two bits a cycle
               if (bit_ff == '0) begin
                  state_ff <= StDone;
               end else begin
                  if (vq_ff >= rb) begin
                     vq_ff   <= vq_ff - rb;
                     root_ff <= (root_ff >> 1) + bit_ff;
                  end else begin
                     root_ff <= root_ff >> 1;
                  end
                  bit_ff <= bit_ff >> 2;
               end
            end
            StDone: begin
               if (!res_v_ff || res_pop) begin
                  res_v_ff <= 1'b1;
                  if (count_ff == '0) begin
                     res_ff <= '{default: '0, empty_list: 1'b1};
                  end else begin
                     res_ff.mean_value <= lmsd_pkg::ValueWidth'(mean_ff);
                     res_ff.std_deviation <= (root_ff[QW-1:lmsd_pkg::ValueWidth] != '0)
                        ? '1 : root_ff[lmsd_pkg::ValueWidth-1:0];
                     res_ff.number_count <= count_ff;
                     res_ff.last_number_position <= pos_ff;
                     res_ff.empty_list <= 1'b0;
                     res_ff.overflowed <= ovf_ff;
                  end
                  count_ff <= '0;
                  sum_ff   <= '0;
                  state_ff <= StLoad;
               end
            end
            default: state_ff <= StLoad;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(lmsd_pkg::MaxNumbers))
      else $error("count beyond capacity");
   assert property (@(posedge clock) disable iff (reset)
      in_pop |-> state_ff == StLoad)
      else $error("pop outside load");
   assert property (@(posedge clock) disable iff (reset)
      (res_v_ff && !res_pop) |=> $stable(res_ff))
      else $error("result changed while held");

endmodule
`default_nettype wire

// ===== design/list_mean_and_std_deviation.sv =====
// Mean and population standard deviation of a list of Q16.8 numbers.
// Input channel: req_push/req_full carry one item word (value, number flag,
// position, last mark). Items without the number flag are skipped; a last
// mark on any item closes the list. Up to 1024 numbers are kept; further
// numbers are dropped and flagged as overflowed.
// Result channel: rsp_empty/rsp_pop; one result word per list, on its last item.
// Loading moves one item per cycle, while the back end is in its load state,
// through a four-word queue into the store. At list end the back end runs a
// bit-serial mean divide, a sweep of the store at one entry a cycle, a
// bit-serial divide by the count and a square root; the sweep's single RAM
// read port and the bit-serial dividers set how long a list takes to finish.
// New items queue up meanwhile.
// Reset clears all list state and drops any pending result. A stalled result
// waits in its register; the back end then holds the next list's end.
`default_nettype none
module list_mean_and_std_deviation (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic signed [23:0] req_sample_value,
   input  wire logic               req_is_number,
   input  wire logic [15:0]        req_position,
   input  wire logic               req_last_item,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic signed [23:0]      rsp_mean_value,
   output logic [23:0]             rsp_std_deviation,
   output logic [10:0]             rsp_number_count,
   output logic [15:0]             rsp_last_number_position,
   output logic                    rsp_empty_list,
   output logic                    rsp_overflowed
);

   lmsd_pkg::item_type   f_item, q_item;
   lmsd_pkg::result_type res;
   logic f_valid, f_ovf, q_ovf, q_empty, q_pop, res_valid;

   lmsd_front u_front (
      .clock, .reset,
      .req_valid(req_push && !req_full),
      .req_sample_value, .req_is_number, .req_position, .req_last_item,
      .item_out(f_item), .item_valid(f_valid),
      .list_overflow(f_ovf)
   );

   lmsd_queue u_queue (
      .clock, .reset,
      .push(f_valid), .push_item(f_item), .push_ovf(f_ovf), .full(req_full),
      .pop(q_pop), .pop_item(q_item), .pop_ovf(q_ovf), .empty(q_empty)
   );

   lmsd_back u_back (
      .clock, .reset,
      .in_valid(!q_empty), .in_item(q_item), .in_ovf(q_ovf), .in_pop(q_pop),
      .res, .res_valid, .res_pop(rsp_pop)
   );

   assign rsp_empty                = !res_valid;
   assign rsp_mean_value           = res.mean_value;
   assign rsp_std_deviation        = res.std_deviation;
   assign rsp_number_count         = res.number_count;
   assign rsp_last_number_position = res.last_number_position;
   assign rsp_empty_list           = res.empty_list;
   assign rsp_overflowed           = res.overflowed;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;

   localparam int WatchdogLimit = 20000;
   localparam int HoldCycles    = 3000;

   typedef struct {
      logic signed [23:0] value;
      logic               is_number;
      logic [15:0]        position;
      logic               last;
      logic               drain;
   } word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic signed [23:0] req_sample_value = '0;
   logic               req_is_number = 1'b0;
   logic [15:0]        req_position = '0;
   logic               req_last_item = 1'b0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic signed [23:0] rsp_mean_value;
   logic [23:0]        rsp_std_deviation;
   logic [10:0]        rsp_number_count;
   logic [15:0]        rsp_last_number_position;
   logic               rsp_empty_list;
   logic               rsp_overflowed;

   word_type             pending_words[$];
   lmsd_pkg::result_type expected_stats[$];
   int         failures = 0;
   int         results_seen = 0;
   int         idle_cycles = 0;
   logic       word_taken = 1'b0;

   // list state of the predictor
   logic signed [23:0] kept_values[lmsd_pkg::MaxNumbers];
   int                 kept_count = 0;
   longint             value_sum = 0;
   logic [15:0]        last_pos = '0;
   logic               dropped = 1'b0;

   list_mean_and_std_deviation dut (.*);

   always #2 clock = ~clock;

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch in %s: got %0d, expected %0d", what, got, want);
      failures++;
   endtask

   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 30; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   // fold one accepted word into the list, close the list on a last mark
   task automatic take_word(input logic signed [23:0] v, input logic num,
                            input logic [15:0] pos, input logic last);
      lmsd_pkg::result_type r;
      longint          mean;
      longint          d;
      longint unsigned sq_sum;
      longint unsigned sd;
      if (num) begin
         last_pos = pos;
         if (kept_count < lmsd_pkg::MaxNumbers) begin
            kept_values[kept_count] = v;
            kept_count++;
            value_sum += v;
         end else begin
            dropped = 1'b1;
         end
      end
      if (last) begin
         r = '0;
         if (kept_count == 0) begin
            r.empty_list = 1'b1;
         end else begin
            mean = value_sum / kept_count;
            sq_sum = 0;
            for (int i = 0; i < kept_count; i++) begin
               d = mean - longint'(kept_values[i]);
               if (d < 0) d = -d;
               sq_sum += longint'(d) * longint'(d);
            end
            sd = floor_root(sq_sum / longint'(kept_count));
            if (sd > 64'hFFFFFF) sd = 64'hFFFFFF;
            r.mean_value = mean[23:0];
            r.std_deviation = sd[23:0];
            r.number_count = kept_count[10:0];
            r.last_number_position = last_pos;
            r.overflowed = dropped;
         end
         expected_stats = {expected_stats, r};
         kept_count = 0;
         value_sum = 0;
         last_pos = '0;
         dropped = 1'b0;
      end
   endtask

   // sample the input side
   always @(posedge clock) begin
      word_taken <= !reset && req_push && !req_full;
      if (!reset && req_push && !req_full)
         take_word(req_sample_value, req_is_number, req_position, req_last_item);
   end

   // sample the result side and compare with the oldest expectation
   always @(posedge clock) begin
      lmsd_pkg::result_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         results_seen++;
         if (expected_stats.size() == 0) begin
            $display("unexpected result word");
            failures++;
         end else begin
            e = expected_stats.pop_front();
            if (rsp_mean_value !== e.mean_value)
               report("mean_value", rsp_mean_value, e.mean_value);
            if (rsp_std_deviation !== e.std_deviation)
               report("std_deviation", rsp_std_deviation, e.std_deviation);
            if (rsp_number_count !== e.number_count)
               report("number_count", rsp_number_count, e.number_count);
            if (rsp_last_number_position !== e.last_number_position)
               report("last_number_position", rsp_last_number_position,
                      e.last_number_position);
            if (rsp_empty_list !== e.empty_list)
               report("empty_list", rsp_empty_list, e.empty_list);
            if (rsp_overflowed !== e.overflowed)
               report("overflowed", rsp_overflowed, e.overflowed);
         end
      end
   end

   function automatic int pick_gap(input bit busy);
      int r;
      r = $urandom_range(0, 99);
      if (busy || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // drive input words at the falling edge
   int  send_gap = 0;
   int  send_words = 0;
   always @(negedge clock) begin
      word_type w;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (word_taken) begin
            void'(pending_words.pop_front());
            send_words++;
            send_gap = pick_gap((send_words / 150) % 3 == 1);
         end
         if (send_gap > 0) begin
            send_gap--;
            req_push <= 1'b0;
         end else if (pending_words.size() == 0) begin
            req_push <= 1'b0;
         end else if (pending_words[0].drain) begin
            // pause until every expected result is back
            req_push <= 1'b0;
            if (expected_stats.size() == 0) void'(pending_words.pop_front());
         end else begin
            w = pending_words[0];
            req_push <= 1'b1;
            req_sample_value <= w.value;
            req_is_number <= w.is_number;
            req_position <= w.position;
            req_last_item <= w.last;
         end
      end
   end

   // drive pop at the falling edge, with one long hold-off
   int  pop_gap = 0;
   int  hold_left = 0;
   bit  hold_done = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (!hold_done && results_seen == 36) begin
            hold_done = 1;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (pop_gap > 0) begin
            pop_gap--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if (rsp_pop && !rsp_empty)
               pop_gap = pick_gap((results_seen / 20) % 3 == 2);
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   task automatic add_word(input logic signed [23:0] v, input logic num,
                           input logic [15:0] pos, input logic last);
      word_type w;
      w.value = v;
      w.is_number = num;
      w.position = pos;
      w.last = last;
      w.drain = 1'b0;
      pending_words = {pending_words, w};
   endtask

   task automatic add_drain();
      word_type w;
      w = '{default: 0};
      w.drain = 1'b1;
      pending_words = {pending_words, w};
   endtask

   function automatic logic signed [23:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return (r % 2) ? 24'sh7FFFFF : 24'sh800000;
      if (r < 50) return $signed(24'($urandom_range(0, 4000))) - 24'sd2000;
      return 24'($urandom);
   endfunction

   initial begin
      int words;
      int lists;
      int len;
      bit noise;
      // directed lists: empty, extremes, skipped last, broken order
      add_word(24'sd5, 1'b0, 16'd0, 1'b1);
      add_word(24'sh7FFFFF, 1'b1, 16'hFFFF, 1'b1);
      add_word(24'sh800000, 1'b1, 16'd0, 1'b1);
      add_word(24'sh7FFFFF, 1'b1, 16'd1, 1'b0);
      add_word(24'sh800000, 1'b1, 16'd2, 1'b1);
      add_word(24'sh800000, 1'b1, 16'd3, 1'b0);
      add_word(24'sh800000, 1'b1, 16'd4, 1'b0);
      add_word(24'sh7FFFFF, 1'b1, 16'd5, 1'b1);
      add_word(-24'sd7, 1'b1, 16'd10, 1'b0);
      add_word(24'sd2, 1'b1, 16'd11, 1'b0);
      add_word(24'sh123456, 1'b0, 16'hABCD, 1'b1);
      add_word(24'sd0, 1'b0, 16'd1, 1'b0);
      add_word(24'sd0, 1'b0, 16'd2, 1'b1);
      add_word(-24'sd1, 1'b1, 16'd8, 1'b0);
      add_word(-24'sd2, 1'b1, 16'd9, 1'b1);
      add_drain();
      // overflow: store full plus dropped numbers
      for (int i = 0; i < lmsd_pkg::MaxNumbers + 3; i++)
         add_word((i % 2) ? 24'sh7FFFFF : 24'sh800000, 1'b1, 16'(i),
                  i == lmsd_pkg::MaxNumbers + 2);
      add_drain();
      words = 0;
      lists = 0;
      while (words < 560 || lists < 40) begin
         len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 16)
                                             : $urandom_range(17, 80);
         noise = ($urandom_range(0, 9) == 0);
         for (int i = 0; i < len; i++)
            add_word(pick_value(), noise ? 1'b0 : ($urandom_range(0, 4) != 0),
                     16'($urandom), i == len - 1);
         words += len;
         lists++;
         if (lists % 40 == 20) add_drain();
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (pending_words.size() == 0);
      wait (expected_stats.size() == 0);
      repeat (200) @(posedge clock);
      if (failures == 0 && expected_stats.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end
endmodule
